// ===== rtl/mbtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mbtg_pkg
// Shared types and constants for the multichannel burst trigger generator.
// ----------------------------------------------------------------------------
package mbtg_pkg;

  localparam int CHANNELS_DEF     = 4;
  localparam int COUNTER_BITS_DEF = 32;

  localparam int NUM_WIDTH_REGS = 4;
  localparam int PIN_W          = 4;
  localparam int KIND_W         = 2;
  localparam int BURST_W        = 32;
  localparam int PULSE_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 40;

  localparam int LED_DIV   = 15;
  localparam int LED_REM_W = 4;

  localparam logic [CFG_DATA_W-1:0] RELOAD_RST = 32'd3999999;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_BURST = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELOAD    = 3'd0,
    CFG_WIDTH_CH0 = 3'd1,
    CFG_WIDTH_CH1 = 3'd2,
    CFG_WIDTH_CH2 = 3'd3,
    CFG_WIDTH_CH3 = 3'd4,
    CFG_POLARITY  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [BURST_W-1:0] burst_count;
    kind_t              kind;
  } item_t;

  typedef struct packed {
    logic               refused;
    logic               burst_done;
    logic               led;
    logic [PULSE_W-1:0] pulse_count;
    logic               running;
    logic [PIN_W-1:0]   pins;
  } result_t;

endpackage

// ===== rtl/mbtg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbtg_cfg_regs
// Configuration register file: reload value, channel widths, polarity.
// ----------------------------------------------------------------------------
module mbtg_cfg_regs #(
  parameter int CHANNELS     = mbtg_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = mbtg_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mbtg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbtg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [COUNTER_BITS-1:0]          reload_r,
  output logic [COUNTER_BITS-1:0]          width_r [CHANNELS],
  output logic                             polarity_r
);
  import mbtg_pkg::*;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r   <= RELOAD_RST[COUNTER_BITS-1:0];
      polarity_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RELOAD:   reload_r   <= cfg_wdata[COUNTER_BITS-1:0];
        CFG_POLARITY: polarity_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Channels past the width registers keep a zero width forever.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (!rst_n) begin
        width_r[i] <= '0;
      end else if (cfg_we && (i < NUM_WIDTH_REGS) &&
                   (cfg_index == CFG_WIDTH_CH0 + CFG_IDX_W'(i))) begin
        width_r[i] <= cfg_wdata[COUNTER_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/mbtg_in_stage.sv =====
// ----------------------------------------------------------------------------
// mbtg_in_stage
// Input register: holds one item until the core consumes it.
// ----------------------------------------------------------------------------
module mbtg_in_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mbtg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [mbtg_pkg::KIND_W-1:0]      in_tuser,
  input  logic                             take,
  output logic                             item_valid,
  output mbtg_pkg::item_t                  item
);
  import mbtg_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind        <= kind_t'(in_tuser);
      item_r.burst_count <= in_tdata[BURST_W-1:0];
    end
  end

endmodule

// ===== rtl/mbtg_core.sv =====
// ----------------------------------------------------------------------------
// mbtg_core
// Shared counter, compare registers, pulse and burst bookkeeping.
// ----------------------------------------------------------------------------
module mbtg_core #(
  parameter int CHANNELS     = mbtg_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = mbtg_pkg::COUNTER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  mbtg_pkg::item_t          item,
  input  logic [COUNTER_BITS-1:0]  reload,
  input  logic [COUNTER_BITS-1:0]  width [CHANNELS],
  input  logic                     polarity,
  output mbtg_pkg::result_t        res
);
  import mbtg_pkg::*;

  localparam int LVL_W = (CHANNELS > PIN_W) ? CHANNELS : PIN_W;

  logic [COUNTER_BITS-1:0] count_r,  count_nxt;
  logic                    running_r, running_nxt;
  logic [PULSE_W-1:0]      pulses_r, pulses_nxt;
  logic [BURST_W-1:0]      burst_r,  burst_nxt;
  logic [COUNTER_BITS-1:0] cmp_r   [CHANNELS];
  logic [COUNTER_BITS-1:0] cmp_nxt [CHANNELS];
  logic [LED_REM_W-1:0]    led_rem_r, led_rem_nxt;
  logic                    led_r, led_nxt;

  logic [COUNTER_BITS-1:0] w_eff [CHANNELS];
  logic [CHANNELS-1:0]     over;
  logic [CHANNELS-1:0]     lt_cur;
  logic [CHANNELS-1:0]     lt_start;
  logic [CHANNELS-1:0]     lvl;
  logic [LVL_W-1:0]        lvl_ext;
  logic [COUNTER_BITS-1:0] count_start;
  logic                    wrap;
  logic                    pulse_inc;
  logic                    pulse_clr;
  logic                    done;
  logic                    refused;

  // Start and burst checks run beside the level compares.
  always_comb begin
    count_start = running_r ? count_r : '0;
    wrap        = (count_r >= reload);
    for (int i = 0; i < CHANNELS; i++) begin
      w_eff[i]    = (width[i] == '0) ? COUNTER_BITS'(1) : width[i];
      over[i]     = (w_eff[i] > reload);
      lt_cur[i]   = (count_r < cmp_r[i]);
      lt_start[i] = (count_start < w_eff[i]);
    end
  end

  always_comb begin
    count_nxt   = count_r;
    running_nxt = running_r;
    burst_nxt   = burst_r;
    cmp_nxt     = cmp_r;
    lvl         = lt_cur;
    pulse_inc   = 1'b0;
    pulse_clr   = 1'b0;
    done        = 1'b0;
    refused     = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        if (running_r) begin
          if (wrap) begin
            count_nxt = '0;
            pulse_inc = 1'b1;
            if (burst_r != '0) begin
              if (burst_r == BURST_W'(1)) begin
                running_nxt = 1'b0;
                burst_nxt   = '0;
                for (int i = 0; i < CHANNELS; i++) cmp_nxt[i] = '0;
                done = 1'b1;
              end else begin
                burst_nxt = burst_r - BURST_W'(1);
              end
            end
          end else begin
            count_nxt = count_r + COUNTER_BITS'(1);
          end
        end
      end
      KIND_STOP: begin
        running_nxt = 1'b0;
        burst_nxt   = '0;
        for (int i = 0; i < CHANNELS; i++) cmp_nxt[i] = '0;
        lvl = '0;
      end
      KIND_START, KIND_BURST: begin
        if (item.kind == KIND_BURST && item.burst_count == '0) begin
          refused = 1'b1;
        end else begin
          if (item.kind == KIND_BURST) begin
            pulse_clr = 1'b1;
            burst_nxt = item.burst_count;
          end
          if (|over) begin
            running_nxt = 1'b0;
            burst_nxt   = '0;
            for (int i = 0; i < CHANNELS; i++) cmp_nxt[i] = '0;
            lvl     = '0;
            refused = 1'b1;
          end else begin
            cmp_nxt     = w_eff;
            count_nxt   = count_start;
            running_nxt = 1'b1;
            lvl         = lt_start;
          end
        end
      end
      default: ;
    endcase
  end

  // led = bit 0 of pulses / 15, tracked as a remainder and a quotient bit.
  // 2^32 is not a multiple of 15, so the 32-bit count's rollover clears both.
  always_comb begin
    pulses_nxt  = pulses_r;
    led_rem_nxt = led_rem_r;
    led_nxt     = led_r;
    if (pulse_clr) begin
      pulses_nxt  = '0;
      led_rem_nxt = '0;
      led_nxt     = 1'b0;
    end else if (pulse_inc) begin
      pulses_nxt = pulses_r + PULSE_W'(1);
      if (pulses_r == '1) begin
        led_rem_nxt = '0;
        led_nxt     = 1'b0;
      end else if (led_rem_r == LED_REM_W'(LED_DIV - 1)) begin
        led_rem_nxt = '0;
        led_nxt     = ~led_r;
      end else begin
        led_rem_nxt = led_rem_r + LED_REM_W'(1);
      end
    end
  end

  always_comb begin
    lvl_ext         = LVL_W'(lvl);
    res.pins        = lvl_ext[PIN_W-1:0] ^ {PIN_W{~polarity}};
    res.running     = running_nxt;
    res.pulse_count = pulses_nxt;
    res.led         = led_nxt;
    res.burst_done  = done;
    res.refused     = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      running_r <= 1'b0;
      pulses_r  <= '0;
      burst_r   <= '0;
      led_rem_r <= '0;
      led_r     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) cmp_r[i] <= '0;
    end else if (fire) begin
      count_r   <= count_nxt;
      running_r <= running_nxt;
      pulses_r  <= pulses_nxt;
      burst_r   <= burst_nxt;
      led_rem_r <= led_rem_nxt;
      led_r     <= led_nxt;
      cmp_r     <= cmp_nxt;
    end
  end

endmodule

// ===== rtl/mbtg_out_stage.sv =====
// ----------------------------------------------------------------------------
// mbtg_out_stage
// Result register driving the output stream.
// ----------------------------------------------------------------------------
module mbtg_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  mbtg_pkg::result_t                 res,
  output logic                              can_load,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbtg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);
  import mbtg_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.burst_done;
  assign out_tdata  = {1'b0, res_r.refused, res_r.led, res_r.pulse_count,
                       res_r.running, res_r.pins};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/multichannel_burst_trigger_generator.sv =====
// ----------------------------------------------------------------------------
// multichannel_burst_trigger_generator
// Multichannel trigger generator on one shared counter, with burst count.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer per timer tick or command. in_tuser carries
//   the kind (tick, start, stop, start burst); in_tdata the burst count.
//   Output stream: one result transfer per input transfer, in order.
//   Config port: cfg_we/cfg_index/cfg_wdata, written while the block idles;
//   width registers take effect at the next start or burst.
// Path: each input transfer lands in the input register, and its result is
//   then loaded into the result register, which offers it on the output.
// Throughput: 1 transfer per cycle without output stalls; the whole counter,
//   compare and burst update of an item is one core pass between the registers.
// Reset: counter, pulse count, burst count and compares clear, outputs idle,
//   config returns to its defaults, both stream stages empty.
// Stall: with out_tready low the result register holds; the input register
//   takes one more transfer, then in_tready drops until the result drains.
// ----------------------------------------------------------------------------
module multichannel_burst_trigger_generator #(
  parameter int CHANNELS     = mbtg_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = mbtg_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: burst_count[31:0]
  input  logic [mbtg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: kind[1:0]
  input  logic [mbtg_pkg::KIND_W-1:0]       in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: pins[3:0], running[4], pulse_count[36:5], led[37],
  //            refused[38], zero[39]
  output logic [mbtg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tlast: burst_done
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [mbtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbtg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mbtg_pkg::*;

  logic [COUNTER_BITS-1:0] reload;
  logic [COUNTER_BITS-1:0] width [CHANNELS];
  logic                    polarity;
  logic                    item_valid;
  item_t                   item;
  result_t                 res;
  logic                    can_load;
  logic                    fire;

  assign fire = item_valid && can_load;

  mbtg_cfg_regs #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .reload_r   (reload),
    .width_r    (width),
    .polarity_r (polarity)
  );

  mbtg_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  mbtg_core #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item),
    .reload   (reload),
    .width    (width),
    .polarity (polarity),
    .res      (res)
  );

  mbtg_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/mbtg_checker.sv =====
// ----------------------------------------------------------------------------
// mbtg_checker
// Port-level checks for the trigger generator, bound to the top level.
// ----------------------------------------------------------------------------
module mbtg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic [mbtg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[4] && !out_tdata[38])
    else $error("burst end while still running or refused");

  a_led_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[36:5] < 32'd15) |-> !out_tdata[37])
    else $error("led set before fifteen pulses");

endmodule

bind multichannel_burst_trigger_generator mbtg_checker u_mbtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== test/tb_multichannel_burst_trigger_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_burst_trigger_generator
// Self-checking regression for the burst trigger generator. A local copy of
// the counter, compare and burst state predicts every result transfer. The
// run covers directed corner cases, an output stall that backs up the input,
// and random command traffic under three idle patterns.
// ----------------------------------------------------------------------------
module tb_multichannel_burst_trigger_generator;
  import mbtg_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;
  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [PIN_W-1:0]   pins;
    logic               running;
    logic [PULSE_W-1:0] pulse_count;
    logic               led;
    logic               burst_done;
    logic               refused;
  } trig_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // predicted generator state and register copies
  logic [31:0] reload_q;
  logic [31:0] width_q [4];
  logic        polarity_q;
  logic [31:0] count_q;
  logic        running_q;
  logic [31:0] pulses_q;
  logic [31:0] burst_left_q;
  logic [31:0] compare_q [4];

  trig_report_t report_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int bursts_ended = 0;
  int refusals_seen = 0;
  int writes_done = 0;
  int cycle_count = 0;

  multichannel_burst_trigger_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  task automatic halt_generator();
    for (int i = 0; i < 4; i++) compare_q[i] = '0;
    running_q = 1'b0;
    burst_left_q = '0;
  endtask

  task automatic try_start(output bit ok);
    logic [31:0] w [4];
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      w[i] = (width_q[i] == '0) ? 32'd1 : width_q[i];
      if (w[i] > reload_q) ok = 1'b0;
    end
    if (ok) begin
      for (int i = 0; i < 4; i++) compare_q[i] = w[i];
      if (!running_q) count_q = '0;
      running_q = 1'b1;
    end
  endtask

  function automatic logic [PIN_W-1:0] channel_levels();
    logic [PIN_W-1:0] p;
    p = '0;
    for (int i = 0; i < 4; i++) if (count_q < compare_q[i]) p[i] = 1'b1;
    if (!polarity_q) p = ~p;
    return p;
  endfunction

  task automatic advance_generator(input kind_t kind, input logic [31:0] n,
                                   output trig_report_t rep);
    bit ok;
    logic [31:0] led_div;
    rep = '0;
    case (kind)
      KIND_TICK: begin
        rep.pins = channel_levels();
        if (running_q) begin
          if (count_q >= reload_q) begin
            count_q = '0;
            pulses_q = pulses_q + 32'd1;
            if (burst_left_q != '0) begin
              if (burst_left_q <= 32'd1) begin
                halt_generator();
                rep.burst_done = 1'b1;
              end else begin
                burst_left_q = burst_left_q - 32'd1;
              end
            end
          end else begin
            count_q = count_q + 32'd1;
          end
        end
      end
      KIND_START: begin
        try_start(ok);
        if (!ok) begin
          halt_generator();
          rep.refused = 1'b1;
        end
      end
      KIND_STOP: halt_generator();
      KIND_BURST: begin
        if (n == '0) begin
          rep.refused = 1'b1;
        end else begin
          pulses_q = '0;
          burst_left_q = n;
          try_start(ok);
          if (!ok) begin
            halt_generator();
            rep.refused = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (kind != KIND_TICK) rep.pins = channel_levels();
    led_div = pulses_q / 32'(LED_DIV);
    rep.running = running_q;
    rep.pulse_count = pulses_q;
    rep.led = led_div[0];
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input kind_t kind, input logic [31:0] n);
    trig_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = $urandom;
      in_tuser = KIND_W'($urandom_range(3));
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = n;
    do @(posedge clk); while (in_tready !== 1'b1);
    advance_generator(kind, n, rep);
    report_q.push_back(rep);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_RELOAD:    reload_q = value;
      CFG_WIDTH_CH0: width_q[0] = value;
      CFG_WIDTH_CH1: width_q[1] = value;
      CFG_WIDTH_CH2: width_q[2] = value;
      CFG_WIDTH_CH3: width_q[3] = value;
      CFG_POLARITY:  polarity_q = value[0];
      default: ;
    endcase
    writes_done++;
  endtask

  // drop valid, let every pending result drain, then let the pipe go quiet
  task automatic settle();
    in_tvalid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_result();
    trig_report_t want;
    logic bad;
    results_seen++;
    if (report_q.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected result transfer: tdata=%h tlast=%b", out_tdata, out_tlast);
    end else begin
      want = report_q.pop_front();
      if (want.burst_done) bursts_ended++;
      if (want.refused) refusals_seen++;
      bad = (out_tdata[3:0] !== want.pins) || (out_tdata[4] !== want.running) ||
            (out_tdata[36:5] !== want.pulse_count) || (out_tdata[37] !== want.led) ||
            (out_tdata[38] !== want.refused) || (out_tdata[39] !== 1'b0) ||
            (out_tlast !== want.burst_done);
      if (bad) begin
        error_count++;
        if (error_count <= 10) begin
          $display("result %0d mismatch: exp pins=%h run=%b cnt=%0d led=%b done=%b ref=%b",
                   results_seen, want.pins, want.running, want.pulse_count, want.led,
                   want.burst_done, want.refused);
          $display("  got pins=%h run=%b cnt=%0d led=%b done=%b ref=%b pad=%b",
                   out_tdata[3:0], out_tdata[4], out_tdata[36:5], out_tdata[37],
                   out_tlast, out_tdata[38], out_tdata[39]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) check_result();
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, report_q.size());
    $display("multichannel_burst_trigger_generator regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  task automatic test_idle_after_reset();
    send_item(KIND_TICK, WORD_MAX);
    send_item(KIND_START, '0);
    send_item(KIND_TICK, '0);
    send_item(KIND_TICK, 32'h5555_AAAA);
    send_item(KIND_STOP, '0);
  endtask

  task automatic test_refused_starts();
    settle();
    write_reg(CFG_RELOAD, 32'd3);
    write_reg(CFG_WIDTH_CH0, 32'd0);
    write_reg(CFG_WIDTH_CH1, 32'd1);
    write_reg(CFG_WIDTH_CH2, 32'd3);
    write_reg(CFG_WIDTH_CH3, 32'd4);
    write_reg(CFG_POLARITY, 32'd1);
    write_reg(CFG_UNUSED_IDX, WORD_MAX);
    send_item(KIND_START, '0);
    send_item(KIND_BURST, '0);
    send_item(KIND_BURST, 32'd5);
    settle();
    write_reg(CFG_WIDTH_CH3, 32'd2);
    send_item(KIND_START, WORD_MAX);
  endtask

  // burst of one issued while running; inverted pins
  task automatic test_single_burst();
    settle();
    write_reg(CFG_POLARITY, 32'd0);
    send_item(KIND_BURST, 32'd1);
    repeat (4) send_item(KIND_TICK, '0);
  endtask

  task automatic test_reload_extremes();
    settle();
    write_reg(CFG_RELOAD, WORD_MAX);
    write_reg(CFG_WIDTH_CH0, WORD_MAX);
    write_reg(CFG_WIDTH_CH1, WORD_MAX);
    write_reg(CFG_WIDTH_CH2, WORD_MAX);
    write_reg(CFG_WIDTH_CH3, WORD_MAX);
    send_item(KIND_START, '0);
    send_item(KIND_TICK, '0);
    send_item(KIND_STOP, '0);
    settle();
    write_reg(CFG_RELOAD, 32'd6);
    write_reg(CFG_WIDTH_CH0, 32'd2);
    write_reg(CFG_WIDTH_CH1, 32'd0);
    write_reg(CFG_WIDTH_CH2, 32'd6);
    write_reg(CFG_WIDTH_CH3, 32'd3);
    write_reg(CFG_POLARITY, 32'd1);
    send_item(KIND_START, '0);
    repeat (5) send_item(KIND_TICK, '0);
    // reload drops below the live count; widths change without a restart
    settle();
    write_reg(CFG_RELOAD, 32'd1);
    write_reg(CFG_WIDTH_CH2, 32'd0);
    send_item(KIND_TICK, '0);
    send_item(KIND_STOP, '0);
  endtask

  task automatic test_output_stall();
    int saved_pct;
    settle();
    write_reg(CFG_RELOAD, 32'd4);
    write_reg(CFG_WIDTH_CH0, 32'd1);
    write_reg(CFG_WIDTH_CH1, 32'd2);
    write_reg(CFG_WIDTH_CH2, 32'd3);
    write_reg(CFG_WIDTH_CH3, 32'd4);
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    send_item(KIND_START, '0);
    stall_left = 80;
    repeat (30) send_item(KIND_TICK, $urandom);
    settle();
    repeat (10) send_item(KIND_TICK, $urandom);
    send_idle_pct = saved_pct;
  endtask

  task automatic pick_random_setting();
    logic [31:0] top;
    logic [31:0] w;
    int r;
    r = $urandom_range(99);
    if (r < 70) top = $urandom_range(8, 1);
    else if (r < 90) top = $urandom_range(40, 9);
    else top = $urandom;
    if (top == '0) top = 32'd1;
    write_reg(CFG_RELOAD, top);
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(99);
      if (r < 3) w = (top == WORD_MAX) ? WORD_MAX : top + 32'd1;
      else if (r < 5) w = WORD_MAX;
      else w = $urandom_range(top, 0);
      write_reg(CFG_IDX_W'(CFG_WIDTH_CH0 + i), w);
    end
    write_reg(CFG_POLARITY, $urandom_range(1));
  endtask

  task automatic random_traffic(input int count);
    int r;
    logic [31:0] n;
    repeat (count) begin
      r = $urandom_range(99);
      n = $urandom;
      if (r < 80) begin
        send_item(KIND_TICK, n);
      end else if (r < 86) begin
        send_item(KIND_START, n);
      end else if (r < 89) begin
        send_item(KIND_STOP, n);
      end else begin
        r = $urandom_range(99);
        if (r < 80) n = $urandom_range(4, 1);
        else if (r < 90) n = '0;
        send_item(KIND_BURST, n);
      end
    end
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      settle();
      pick_random_setting();
      random_traffic(90);
    end
  endtask

  initial begin
    reload_q = RELOAD_RST;
    for (int i = 0; i < 4; i++) begin
      width_q[i] = '0;
      compare_q[i] = '0;
    end
    polarity_q = 1'b1;
    count_q = '0;
    running_q = 1'b0;
    pulses_q = '0;
    burst_left_q = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 74;
    test_idle_after_reset();
    test_refused_starts();
    test_single_burst();
    test_reload_extremes();
    test_output_stall();
    test_random_phase(19, 74);
    test_random_phase(74, 19);
    test_random_phase(0, 0);
    settle();
    repeat (10) @(posedge clk);
    $display("run covered %0d input transfers, %0d results, %0d register writes",
             items_sent, results_seen, writes_done);
    $display("  with %0d completed bursts and %0d refused commands, %0d mismatches",
             bursts_ended, refusals_seen, error_count);
    if (error_count == 0 && report_q.size() == 0) begin
      $display("multichannel_burst_trigger_generator regression: pass");
    end else begin
      $display("multichannel_burst_trigger_generator regression: fail");
    end
    $finish;
  end

endmodule

// ===== multichannel_burst_trigger_generator.f =====
rtl/mbtg_pkg.sv
rtl/mbtg_cfg_regs.sv
rtl/mbtg_in_stage.sv
rtl/mbtg_core.sv
rtl/mbtg_out_stage.sv
rtl/multichannel_burst_trigger_generator.sv
rtl/mbtg_checker.sv
test/tb_multichannel_burst_trigger_generator.sv
